// ===== design/geo_box_pair_relate_union_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for geo_box_pair_relate_union
// Immediate-implication and next-cycle-implication checks on clk, with
// synchronous active-low reset masking; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GEO_BOX_PAIR_RELATE_UNION_ASSERT_SVH
`define GEO_BOX_PAIR_RELATE_UNION_ASSERT_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define GBRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbru assertion failed");
// Check that cons holds in the cycle after ante.
`define GBRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbru assertion failed");
`else
`define GBRU_ASSERT_NOW(label, ante, cons)
`define GBRU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/gbru_pkg.sv =====
// ----------------------------------------------------------------------------
// gbru_pkg
// Shared types, constants and helpers for the box pair relate/union block.
// ----------------------------------------------------------------------------
package gbru_pkg;

  localparam int LAT_W       = 28;
  localparam int LON_W       = 29;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 120;

  // Microdegree limits, held at 32 bits so the edge sum l1 + r1 - l2 - r2 fits.
  localparam logic signed [31:0] LAT_MAX  = 32'sd90000000;
  localparam logic signed [31:0] LON_MAX  = 32'sd180000000;
  localparam logic signed [31:0] LON_SPAN = 32'sd360000000;

  typedef struct packed {
    logic signed [LAT_W-1:0] a_top;
    logic signed [LAT_W-1:0] a_bottom;
    logic signed [LON_W-1:0] a_left;
    logic signed [LON_W-1:0] a_right;
    logic signed [LAT_W-1:0] b_top;
    logic signed [LAT_W-1:0] b_bottom;
    logic signed [LON_W-1:0] b_left;
    logic signed [LON_W-1:0] b_right;
  } box_pair_t;

  typedef struct packed {
    logic                    overlap;
    logic                    encloses;
    logic signed [LAT_W-1:0] union_top;
    logic signed [LAT_W-1:0] union_bottom;
    logic signed [LON_W-1:0] union_left;
    logic signed [LON_W-1:0] union_right;
  } result_t;

  function automatic logic signed [31:0] sx_lat(input logic [LAT_W-1:0] v);
    return {{(32-LAT_W){v[LAT_W-1]}}, v};
  endfunction

  function automatic logic signed [31:0] sx_lon(input logic [LON_W-1:0] v);
    return {{(32-LON_W){v[LON_W-1]}}, v};
  endfunction

endpackage

// ===== design/gbru_rel.sv =====
// ----------------------------------------------------------------------------
// gbru_rel
// Intersection and containment tests for one registered box pair.
// ----------------------------------------------------------------------------
module gbru_rel import gbru_pkg::*; (
  input  box_pair_t bp,
  output logic      overlap,
  output logic      encloses
);

  function automatic logic pt_ok(input logic signed [31:0] lat,
                                 input logic signed [31:0] lon);
    return (lat >= -LAT_MAX) && (lat <= LAT_MAX) && (lon >= -LON_MAX) && (lon <= LON_MAX);
  endfunction

  // Corner (lat, lon) inside box t/b/l/r, poles shared across longitudes.
  function automatic logic holds(input logic signed [31:0] t, input logic signed [31:0] b,
                                 input logic signed [31:0] l, input logic signed [31:0] r,
                                 input logic signed [31:0] lat,
                                 input logic signed [31:0] lon);
    logic in_lat;
    logic pole;
    logic in_lon;
    in_lat = !((lat > t) || (lat < b));
    pole   = ((lat == LAT_MAX) && (t == LAT_MAX)) || ((lat == -LAT_MAX) && (b == -LAT_MAX));
    if (l <= r) begin
      in_lon = !((lon < l) || (lon > r));
    end else begin
      in_lon = !((lon < l) && (lon > r));
    end
    return pt_ok(lat, lon) && in_lat && (pole || in_lon);
  endfunction

  logic signed [31:0] at, ab, al, ar, bt, bb, bl, br;
  logic lat_sep, poles, lon_meet;
  logic a_ok, b_ok;

  always_comb begin
    at = sx_lat(bp.a_top);
    ab = sx_lat(bp.a_bottom);
    al = sx_lon(bp.a_left);
    ar = sx_lon(bp.a_right);
    bt = sx_lat(bp.b_top);
    bb = sx_lat(bp.b_bottom);
    bl = sx_lon(bp.b_left);
    br = sx_lon(bp.b_right);
  end

  assign lat_sep = (at < bb) || (ab > bt);
  assign poles   = ((at == LAT_MAX) && (bt == LAT_MAX)) ||
                   ((ab == -LAT_MAX) && (bb == -LAT_MAX));

  always_comb begin
    if (al < ar) begin
      if (bl < br) begin
        lon_meet = !((al > br) || (ar < bl));
      end else begin
        lon_meet = !((al > br) && (ar < bl));
      end
    end else if (bl < br) begin
      lon_meet = !((bl > ar) && (br < al));
    end else begin
      lon_meet = 1'b1;
    end
  end

  assign overlap = !lat_sep && (poles || lon_meet);

  assign a_ok = pt_ok(at, al) && pt_ok(ab, ar) && (at >= ab);
  assign b_ok = pt_ok(bt, bl) && pt_ok(bb, br) && (bt >= bb);

  assign encloses = a_ok && b_ok &&
                    holds(at, ab, al, ar, bt, bl) && holds(at, ab, al, ar, bt, br) &&
                    holds(at, ab, al, ar, bb, bl) && holds(at, ab, al, ar, bb, br);

endmodule

// ===== design/gbru_join.sv =====
// ----------------------------------------------------------------------------
// gbru_join
// Union box of one registered box pair, with antimeridian wrap rules.
// ----------------------------------------------------------------------------
module gbru_join import gbru_pkg::*; (
  input  box_pair_t               bp,
  output logic signed [LAT_W-1:0] union_top,
  output logic signed [LAT_W-1:0] union_bottom,
  output logic signed [LON_W-1:0] union_left,
  output logic signed [LON_W-1:0] union_right
);

  logic signed [31:0] l1, r1, l2, r2;
  logic signed [31:0] d, wl, wr, nl, nr, dr, dl;
  logic signed [31:0] left, right;
  logic w1, w2, jl, jr, full1, full2;

  assign union_top    = (bp.a_top > bp.b_top) ? bp.a_top : bp.b_top;
  assign union_bottom = (bp.a_bottom < bp.b_bottom) ? bp.a_bottom : bp.b_bottom;

  always_comb begin
    l1 = sx_lon(bp.a_left);
    r1 = sx_lon(bp.a_right);
    l2 = sx_lon(bp.b_left);
    r2 = sx_lon(bp.b_right);
    w1 = l1 > r1;
    w2 = l2 > r2;
    d  = l1 + r1 - l2 - r2;
    wl = w1 ? l1 : l2;
    wr = w1 ? r1 : r2;
    nl = w1 ? l2 : l1;
    nr = w1 ? r2 : r1;
    jl = nr >= wl;
    jr = nl <= wr;
    dr = nl - wr;
    dl = wl - nr;
    full1 = (l1 == -LON_MAX) && (r1 == LON_MAX);
    full2 = (l2 == -LON_MAX) && (r2 == LON_MAX);

    if (w1 == w2) begin
      // Centers closer than half a turn: widen; farther: take the wrapped join; exactly half: full circle.
      if ((d < LON_SPAN) && (d > -LON_SPAN)) begin
        left  = (l1 < l2) ? l1 : l2;
        right = (r1 > r2) ? r1 : r2;
      end else if ((d > LON_SPAN) || (d < -LON_SPAN)) begin
        left  = (l1 > l2) ? l1 : l2;
        right = (r1 < r2) ? r1 : r2;
      end else begin
        left  = -LON_MAX;
        right = LON_MAX;
      end
    end else if (jl && jr) begin
      left  = -LON_MAX;
      right = LON_MAX;
    end else if (jl) begin
      left  = nl;
      right = wr;
    end else if (jr) begin
      left  = wl;
      right = nr;
    end else if (dl == dr) begin
      left  = -LON_MAX;
      right = LON_MAX;
    end else if (dl < dr) begin
      left  = nl;
      right = wr;
    end else begin
      left  = wl;
      right = nr;
    end

    if (full1 || full2) begin
      left  = -LON_MAX;
      right = LON_MAX;
    end
  end

  assign union_left  = left[LON_W-1:0];
  assign union_right = right[LON_W-1:0];

endmodule

// ===== design/geo_box_pair_relate_union.sv =====
// ----------------------------------------------------------------------------
// geo_box_pair_relate_union
// Relates two geographic boxes (overlap, containment) and forms their union.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ stream carries boxes A and B (top, bottom, left,
//   right in signed microdegrees; left > right means the box wraps across the
//   antimeridian). Each request yields exactly one request on the out_ stream
//   with overlap, encloses and the union box, in arrival order.
//   A request is captured in an input register, evaluated by the relate and
//   join logic, and captured in the result register.
//   Throughput: one request per cycle while out_tready stays high; every stage
//   advances whenever the stage after it is empty or being drained.
//   Reset (rst_n low at a clock edge) empties both stages; no other state.
//   When the receiver holds out_tready low, the result register holds, the
//   input register fills behind it, and in_tready drops only once both are
//   occupied; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "geo_box_pair_relate_union_assert.svh"

module geo_box_pair_relate_union import gbru_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata from bit 0: a_top[28], a_bottom[28], a_left[29], a_right[29],
  //   b_top[28], b_bottom[28], b_left[29], b_right[29], 4 unused bits
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata from bit 0: overlap[1], encloses[1], union_top[28],
  //   union_bottom[28], union_left[29], union_right[29], 4 zero bits
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  box_pair_t s1_r, s1_nxt;
  logic      s1_v_r;
  result_t   res_r, res_nxt;
  logic      res_v_r;
  logic      s2_ready;

  // Unpack the request fields.
  always_comb begin
    s1_nxt.a_top    = in_tdata[27:0];
    s1_nxt.a_bottom = in_tdata[55:28];
    s1_nxt.a_left   = in_tdata[84:56];
    s1_nxt.a_right  = in_tdata[113:85];
    s1_nxt.b_top    = in_tdata[141:114];
    s1_nxt.b_bottom = in_tdata[169:142];
    s1_nxt.b_left   = in_tdata[198:170];
    s1_nxt.b_right  = in_tdata[227:199];
  end

  // Advance a stage when the one after it is empty or draining.
  assign s2_ready  = !res_v_r || out_tready;
  assign in_tready = !s1_v_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= s1_nxt;
    end
  end

  gbru_rel u_rel (
    .bp       (s1_r),
    .overlap  (res_nxt.overlap),
    .encloses (res_nxt.encloses)
  );

  gbru_join u_join (
    .bp           (s1_r),
    .union_top    (res_nxt.union_top),
    .union_bottom (res_nxt.union_bottom),
    .union_left   (res_nxt.union_left),
    .union_right  (res_nxt.union_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (s2_ready) begin
      res_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {4'b0000, res_r.union_right, res_r.union_left, res_r.union_bottom,
                       res_r.union_top, res_r.encloses, res_r.overlap};

  // Hold a blocked request in the input stage unchanged.
  `GBRU_ASSERT_NEXT(a_s1_hold, s1_v_r && !s2_ready, s1_v_r && $stable(s1_r))
  // Advance a request into the result register when the result side is free.
  `GBRU_ASSERT_NEXT(a_s1_advance, s1_v_r && s2_ready, res_v_r && (res_r == $past(res_nxt)))
  // Force full width whenever either box already spans the whole circle.
  `GBRU_ASSERT_NOW(a_full_width,
    s1_v_r && (((sx_lon(s1_r.a_left) == -LON_MAX) && (sx_lon(s1_r.a_right) == LON_MAX)) ||
               ((sx_lon(s1_r.b_left) == -LON_MAX) && (sx_lon(s1_r.b_right) == LON_MAX))),
    (sx_lon(res_nxt.union_left) == -LON_MAX) && (sx_lon(res_nxt.union_right) == LON_MAX))

endmodule
